/* sv/etc_pkg.sv */
// ----------------------------------------------------------------------------
// etc_pkg: shared types and constants of the event timing counter table
// Counter entry layout, command and status codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package etc_pkg;

	localparam int NUM_COUNTERS = 128;
	localparam int CNT_AW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

	localparam int ID_W   = 7;
	localparam int DATA_W = 64;

	// command codes
	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_STOP    = 3'd1;
	localparam logic [2:0] CMD_DISCARD = 3'd2;
	localparam logic [2:0] CMD_RESET   = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;

	// status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_IGNORED  = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_NO_START = 2'd3;

	// register map: 64-bit registers at 8-byte spacing, decoded by paddr[3]
	localparam int PADDR_W     = 4;
	localparam int REG_SEL_BIT = 3;
	localparam logic REG_UNLOADING    = 1'b0;
	localparam logic REG_ACTIVE_EVENT = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] start_time;
		logic [DATA_W-1:0] start_event;
		logic [DATA_W-1:0] occ_count;
		logic [DATA_W-1:0] tick_sum;
		logic [DATA_W-1:0] tick_peak;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              unloading;
		logic [DATA_W-1:0] active_event_id;
	} cfg_t;

	// counter id to table address (zero extend, then keep address bits)
	function automatic logic [CNT_AW-1:0] id_to_addr(input logic [ID_W-1:0] id);
		logic [15:0] w;
		begin
			w = 16'(id);
			return w[CNT_AW-1:0];
		end
	endfunction

	function automatic logic id_in_range(input logic [ID_W-1:0] id);
		logic [15:0] w;
		begin
			w = 16'(id);
			return (w < 16'(NUM_COUNTERS));
		end
	endfunction

endpackage

`default_nettype wire

/* sv/event_timing_counter_table_top.sv */
// ----------------------------------------------------------------------------
// event_timing_counter_table_top: profiling counter table with event timing
// Per-counter start/stop interval timing, occurrence count, tick total and
// peak interval, kept in one on-chip table.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                          Payload
// -------   --------------------------------   ---------------------------------
// command   start & !busy                      cmd, counter_id, event_id, now_ticks
// result    done (one-cycle strobe)            status, occurrences, ticks_total,
//                                              ticks_max, start_pending
// config    psel & penable & pwrite (pready=1) paddr, pwdata / prdata
//
// Timing: busy rises once a command is transferred and falls as its result
//   strobe appears, so no new command is taken until the previous one has
//   been through the table read-modify-write: registered read, elapsed/compare
//   logic, then update and write-back.
// Reset: arst_n clears control and the configuration registers. The table is
//   cleared at once through per-entry valid flops; no clearing pass.
// Stalls: the receiver cannot stall; done is high for one cycle, the payload holds until the next result.
//
// Register map (64-bit data, decoded on paddr[3]):
//   0x0 unloading        bit 0; when set start and stop are ignored
//   0x8 active_event_id  start/stop ignored for event ids at or below it
// ----------------------------------------------------------------------------
`default_nettype none

module event_timing_counter_table_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB-style configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [etc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [etc_pkg::DATA_W-1:0]    pwdata,
	output logic      [etc_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	// command channel
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [2:0]                    cmd,
	input  wire logic [etc_pkg::ID_W-1:0]      counter_id,
	input  wire logic [etc_pkg::DATA_W-1:0]    event_id,
	input  wire logic [etc_pkg::DATA_W-1:0]    now_ticks,
	// result channel
	output logic                               done,
	output logic      [1:0]                    status,
	output logic      [etc_pkg::DATA_W-1:0]    occurrences,
	output logic      [etc_pkg::DATA_W-1:0]    ticks_total,
	output logic      [etc_pkg::DATA_W-1:0]    ticks_max,
	output logic                               start_pending
);

	etc_pkg::cfg_t cfg;

	// zero-wait-state config port
	assign pready = 1'b1;

	etc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// table engine: read at transfer, compute, update and write back
	etc_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.counter_id    (counter_id),
		.event_id      (event_id),
		.now_ticks     (now_ticks),
		.done          (done),
		.status        (status),
		.occurrences   (occurrences),
		.ticks_total   (ticks_total),
		.ticks_max     (ticks_max),
		.start_pending (start_pending)
	);

	// every command transfer yields its result strobe
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing three cycles after command transfer");

	// engine holds off new commands while an entry is in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after command transfer");

	// the write-back has finished by the time the result shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while engine still busy");

	// a stop without a prior start cannot leave a start pending
	a_no_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == etc_pkg::ST_NO_START) |-> !start_pending)
		else $error("start pending after stop without start");

endmodule

`default_nettype wire

/* sv/etc_ram.sv */
// ----------------------------------------------------------------------------
// etc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/etc_cfg.sv */
// ----------------------------------------------------------------------------
// etc_cfg: APB-style configuration registers
// Holds the unloading flag and the activation event id.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [etc_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [etc_pkg::DATA_W-1:0]    pwdata,
	output logic      [etc_pkg::DATA_W-1:0]    prdata,
	output etc_pkg::cfg_t                      cfg
);

	logic                         unloading_q;
	logic [etc_pkg::DATA_W-1:0]   active_q;
	logic                         wr;
	logic                         sel;

	assign wr  = psel & penable & pwrite;
	assign sel = paddr[etc_pkg::REG_SEL_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unloading_q <= 1'b0;
			active_q    <= '0;
		end else if (wr) begin
			if (sel == etc_pkg::REG_UNLOADING) begin
				unloading_q <= pwdata[0];
			end else begin
				active_q <= pwdata;
			end
		end
	end

	always_comb begin
		if (sel == etc_pkg::REG_ACTIVE_EVENT) begin
			prdata = active_q;
		end else begin
			prdata = {{(etc_pkg::DATA_W-1){1'b0}}, unloading_q};
		end
	end

	assign cfg.unloading       = unloading_q;
	assign cfg.active_event_id = active_q;

endmodule

`default_nettype wire

/* sv/etc_engine.sv */
// ----------------------------------------------------------------------------
// etc_engine: read-modify-write engine over the counter table
// Accept issues the table read, s1 takes the entry and forms elapsed time
// and event compares, s2 updates, writes back and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire etc_pkg::cfg_t                cfg,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [2:0]                   cmd,
	input  wire logic [etc_pkg::ID_W-1:0]     counter_id,
	input  wire logic [etc_pkg::DATA_W-1:0]   event_id,
	input  wire logic [etc_pkg::DATA_W-1:0]   now_ticks,
	output logic                              done,
	output logic      [1:0]                   status,
	output logic      [etc_pkg::DATA_W-1:0]   occurrences,
	output logic      [etc_pkg::DATA_W-1:0]   ticks_total,
	output logic      [etc_pkg::DATA_W-1:0]   ticks_max,
	output logic                              start_pending
);

	localparam int AW = etc_pkg::CNT_AW;
	localparam int DW = etc_pkg::DATA_W;
	localparam int NUM_VLD = etc_pkg::NUM_COUNTERS;

	logic                      accept;
	logic                      v_s1_q, v_s2_q;
	logic [NUM_VLD-1:0]        vld_q;

	// stage 1 registers
	logic [2:0]                cmd_s1;
	logic [AW-1:0]             addr_s1;
	logic                      inr_s1;
	logic [DW-1:0]             ev_s1;
	logic [DW-1:0]             now_s1;

	// stage 2 registers
	logic [2:0]                cmd_s2;
	logic [AW-1:0]             addr_s2;
	logic                      inr_s2;
	logic [DW-1:0]             ev_s2;
	logic [DW-1:0]             now_s2;
	logic                      gated_s2;
	logic                      ev_eq_s2;
	logic                      pend_s2;
	logic [DW-1:0]             elapsed_s2;
	etc_pkg::entry_t           ent_s2;

	logic [etc_pkg::ENTRY_W-1:0] rd_data;
	etc_pkg::entry_t           ent_s1;
	etc_pkg::entry_t           ent_new;
	logic [1:0]                st_new;
	logic                      we;

	assign busy   = v_s1_q | v_s2_q;
	assign accept = start & ~busy;
	assign we     = v_s2_q & inr_s2;

	etc_ram #(
		.WIDTH (etc_pkg::ENTRY_W),
		.DEPTH (etc_pkg::NUM_COUNTERS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s2),
		.wdata (ent_new),
		.re    (accept),
		.raddr (etc_pkg::id_to_addr(counter_id)),
		.rdata (rd_data)
	);

	// entries never written read as zero
	always_comb begin
		if (inr_s1 && vld_q[addr_s1]) begin
			ent_s1 = rd_data;
		end else begin
			ent_s1 = '0;
		end
	end

	// update of the entry
	always_comb begin
		ent_new = ent_s2;
		st_new  = etc_pkg::ST_DONE;
		case (cmd_s2)
			etc_pkg::CMD_START: begin
				if (gated_s2) begin
					st_new = etc_pkg::ST_IGNORED;
				end else begin
					ent_new.start_event = ev_s2;
					ent_new.start_time  = now_s2;
				end
			end
			etc_pkg::CMD_STOP: begin
				if (gated_s2) begin
					st_new = etc_pkg::ST_IGNORED;
				end else begin
					ent_new.occ_count = ent_s2.occ_count + DW'(1);
					if (!ev_eq_s2) begin
						st_new = pend_s2 ? etc_pkg::ST_MISMATCH : etc_pkg::ST_NO_START;
					end else begin
						if (elapsed_s2 > ent_s2.tick_peak) begin
							ent_new.tick_peak = elapsed_s2;
						end
						ent_new.tick_sum    = ent_s2.tick_sum + elapsed_s2;
						ent_new.start_event = '0;
					end
				end
			end
			etc_pkg::CMD_DISCARD: begin
				ent_new.start_event = '0;
			end
			etc_pkg::CMD_RESET: begin
				ent_new.occ_count   = '0;
				ent_new.tick_peak   = '0;
				ent_new.start_event = '0;
				ent_new.start_time  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			done   <= 1'b0;
			vld_q  <= '0;
		end else begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q;
			done   <= v_s2_q;
			if (we) begin
				vld_q[addr_s2] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			addr_s1 <= etc_pkg::id_to_addr(counter_id);
			inr_s1  <= etc_pkg::id_in_range(counter_id);
			ev_s1   <= event_id;
			now_s1  <= now_ticks;
		end
		if (v_s1_q) begin
			cmd_s2     <= cmd_s1;
			addr_s2    <= addr_s1;
			inr_s2     <= inr_s1;
			ev_s2      <= ev_s1;
			now_s2     <= now_s1;
			ent_s2     <= ent_s1;
			gated_s2   <= cfg.unloading | (ev_s1 <= cfg.active_event_id);
			ev_eq_s2   <= (ent_s1.start_event == ev_s1);
			pend_s2    <= (ent_s1.start_event != '0);
			elapsed_s2 <= now_s1 - ent_s1.start_time;
		end
		if (v_s2_q) begin
			if (inr_s2) begin
				status        <= st_new;
				occurrences   <= ent_new.occ_count;
				ticks_total   <= ent_new.tick_sum;
				ticks_max     <= ent_new.tick_peak;
				start_pending <= (ent_new.start_event != '0);
			end else begin
				status        <= etc_pkg::ST_IGNORED;
				occurrences   <= '0;
				ticks_total   <= '0;
				ticks_max     <= '0;
				start_pending <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for event_timing_counter_table_top
// Drives start/stop/discard/reset/read commands through the start/busy port,
// programs the gating registers over APB, and checks every result strobe
// against an in-bench model of the counter table, in order.
// ----------------------------------------------------------------------------

module tb;

	import etc_pkg::*;

	// reserved command codes, decoded by the block as plain reads
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	// cycles with no transfer of any kind before the run is declared hung
	localparam int STALL_LIMIT = 1000;
	// settling wait after the last owed result strobe
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] occ;
		logic [DATA_W-1:0] total;
		logic [DATA_W-1:0] peak;
		logic              pending;
	} counter_report_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [2:0]        cmd;
	logic [ID_W-1:0]   counter_id;
	logic [DATA_W-1:0] event_id;
	logic [DATA_W-1:0] now_ticks;
	logic              done;
	logic [1:0]        status;
	logic [DATA_W-1:0] occurrences;
	logic [DATA_W-1:0] ticks_total;
	logic [DATA_W-1:0] ticks_max;
	logic              start_pending;

	// model of the counter table and the gating registers
	logic [DATA_W-1:0] mark_time  [NUM_COUNTERS];
	logic [DATA_W-1:0] mark_event [NUM_COUNTERS];
	logic [DATA_W-1:0] occ_tab    [NUM_COUNTERS];
	logic [DATA_W-1:0] sum_tab    [NUM_COUNTERS];
	logic [DATA_W-1:0] peak_tab   [NUM_COUNTERS];
	logic              cfg_unloading;
	logic [DATA_W-1:0] cfg_active;

	// reports owed by the block, oldest first
	counter_report_t expected_reports[$];
	counter_report_t want_report;

	int fail_count   = 0;
	int items_sent   = 0;
	int stall_cycles = 0;
	int burst_left   = 0;
	bit gapless      = 0;

	event_timing_counter_table_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.counter_id   (counter_id),
		.event_id     (event_id),
		.now_ticks    (now_ticks),
		.done         (done),
		.status       (status),
		.occurrences  (occurrences),
		.ticks_total  (ticks_total),
		.ticks_max    (ticks_max),
		.start_pending(start_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Table model. Applies one accepted command and returns what the block
	// must report for the addressed counter after it.
	// ------------------------------------------------------------------------
	function automatic counter_report_t apply_command(input logic [2:0] op,
			input logic [ID_W-1:0] id, input logic [DATA_W-1:0] ev,
			input logic [DATA_W-1:0] ticks);
		counter_report_t r;
		logic            gated;
		logic [DATA_W-1:0] elapsed;
		r = '0;
		r.status = ST_DONE;
		// start/stop are held off while unloading or for stale event ids
		gated = cfg_unloading || (ev <= cfg_active);
		if (int'(id) >= NUM_COUNTERS) begin
			r.status = ST_IGNORED;
			return r;
		end
		case (op)
			CMD_START: begin
				if (gated) begin
					r.status = ST_IGNORED;
				end else begin
					// a second start simply overwrites the first
					mark_event[id] = ev;
					mark_time[id]  = ticks;
				end
			end
			CMD_STOP: begin
				if (gated) begin
					r.status = ST_IGNORED;
				end else begin
					occ_tab[id] = occ_tab[id] + 1;
					if (mark_event[id] != ev) begin
						// pending start of another event survives
						r.status = (mark_event[id] != '0) ? ST_MISMATCH : ST_NO_START;
					end else begin
						elapsed = ticks - mark_time[id];
						if (elapsed > peak_tab[id])
							peak_tab[id] = elapsed;
						sum_tab[id]    = sum_tab[id] + elapsed;
						mark_event[id] = '0;
					end
				end
			end
			CMD_DISCARD: begin
				mark_event[id] = '0;
			end
			CMD_RESET: begin
				// tick total is deliberately kept
				occ_tab[id]    = '0;
				peak_tab[id]   = '0;
				mark_event[id] = '0;
				mark_time[id]  = '0;
			end
			default: ;
		endcase
		r.occ     = occ_tab[id];
		r.total   = sum_tab[id];
		r.peak    = peak_tab[id];
		r.pending = (mark_event[id] != '0);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// event ids: mostly just above the gating threshold so that starts and
	// stops land on the same event, some on the threshold, some anywhere
	function automatic logic [DATA_W-1:0] pick_event();
		case ($urandom_range(0, 7))
			0: return rand64();
			1: return cfg_active;
			default: return cfg_active + 64'd1 + 64'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_delta();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return rand64();
			default: return 64'($urandom_range(1, 5000));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checker: every strobe must match the oldest owed report.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d, occurrences %0h",
					$time, status, occurrences);
				fail_count++;
			end else begin
				want_report = expected_reports.pop_front();
				check_field("status", 64'(want_report.status), 64'(status));
				check_field("occurrences", want_report.occ, occurrences);
				check_field("ticks_total", want_report.total, ticks_total);
				check_field("ticks_max", want_report.peak, ticks_max);
				check_field("start_pending", 64'(want_report.pending), 64'(start_pending));
			end
		end
	end

	// Watchdog: any command, result or register transfer resets the count.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Command sender. Works in bursts; unless gapless is set, start drops between
	// bursts for a random number of cycles so gaps hit every cycle of the engine
	// occupancy. start stays high from one transfer to the next in a burst.
	// ------------------------------------------------------------------------
	task automatic send_cmd(input logic [2:0] op, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] ev, input logic [DATA_W-1:0] ticks);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!gapless) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		burst_left--;
		start      <= 1'b1;
		cmd        <= op;
		counter_id <= id;
		event_id   <= ev;
		now_ticks  <= ticks;
		do @(posedge clk); while (busy);
		expected_reports.push_back(apply_command(op, id, ev, ticks));
		items_sent++;
	endtask

	// idle the command port until every owed report is in
	task automatic drain_results();
		start <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write, then read back the same register
	task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
		logic [PADDR_W-1:0] addr;
		logic [DATA_W-1:0]  got;
		addr = '0;
		addr[REG_SEL_BIT] = sel;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_UNLOADING)
			cfg_unloading = value[0];
		else
			cfg_active = value;
		// psel held: straight into the read setup phase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (sel == REG_UNLOADING)
			check_field("unloading readback", 64'(cfg_unloading), 64'(got[0]));
		else
			check_field("active_event_id readback", cfg_active, got);
	endtask

	task automatic send_noise();
		send_cmd(3'($urandom_range(0, 7)), ID_W'($urandom_range(0, 127)),
			$urandom_range(0, 1) ? pick_event() : rand64(), rand64());
	endtask

	// a start/stop pair on one counter, sometimes with traffic in between,
	// a stop on the wrong event, or a second stop
	task automatic timed_interval();
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] ev;
		logic [DATA_W-1:0] t0;
		logic [DATA_W-1:0] stop_ev;
		// a few hot counters so totals and peaks build up
		id = ($urandom_range(0, 2) == 0) ? ID_W'($urandom_range(0, 3))
			: ID_W'($urandom_range(0, 127));
		ev = pick_event();
		t0 = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 100000));
		send_cmd(CMD_START, id, ev, t0);
		if ($urandom_range(0, 3) == 0)
			send_noise();
		stop_ev = ($urandom_range(0, 7) == 0) ? pick_event() : ev;
		send_cmd(CMD_STOP, id, stop_ev, t0 + pick_delta());
		if ($urandom_range(0, 5) == 0)
			send_cmd(CMD_STOP, id, stop_ev, rand64());
	endtask

	// one random phase under a fixed register setting
	task automatic run_traffic(input int target, input logic unl,
			input logic [DATA_W-1:0] act, input bit nogap, input bit pause);
		int first;
		int pause_at;
		first = items_sent;
		drain_results();
		write_reg(REG_UNLOADING, 64'(unl));
		write_reg(REG_ACTIVE_EVENT, act);
		gapless  = nogap;
		pause_at = first + $urandom_range(target / 4, target * 3 / 4);
		while (items_sent - first < target) begin
			if (pause && items_sent >= pause_at) begin
				pause = 0;
				drain_results();
			end
			if ($urandom_range(0, 9) < 7)
				timed_interval();
			else
				send_noise();
		end
		gapless = 0;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// command semantics under the reset register values (active id 0)
	task automatic test_commands();
		send_cmd(CMD_READ, 0, '0, '0);
		send_cmd(CMD_RSVD5, 5, '0, '0);
		send_cmd(CMD_RSVD7, 127, '1, '1);
		// event id 0 is never above the threshold
		send_cmd(CMD_START, 0, '0, 64'd50);
		send_cmd(CMD_START, 0, 64'd1, 64'd100);
		send_cmd(CMD_STOP, 0, 64'd1, 64'd250);
		// stop with nothing pending
		send_cmd(CMD_STOP, 0, 64'd1, 64'd300);
		// shorter interval: total grows, peak stays
		send_cmd(CMD_START, 0, 64'd2, 64'd1000);
		send_cmd(CMD_STOP, 0, 64'd2, 64'd1010);
		// elapsed time wraps through zero
		send_cmd(CMD_START, 127, '1, '1);
		send_cmd(CMD_STOP, 127, '1, 64'd5);
		// stop on another event keeps the pending start; restart overwrites
		send_cmd(CMD_START, 5, 64'd7, 64'd10);
		send_cmd(CMD_STOP, 5, 64'd8, 64'd15);
		send_cmd(CMD_START, 5, 64'd9, 64'd20);
		send_cmd(CMD_STOP, 5, 64'd9, 64'd45);
		// discard drops the pending start
		send_cmd(CMD_START, 3, 64'd2, 64'd50);
		send_cmd(CMD_DISCARD, 3, '0, '0);
		send_cmd(CMD_STOP, 3, 64'd2, 64'd60);
		// reset keeps the tick total
		send_cmd(CMD_RESET, 0, '0, '0);
	endtask

	// gating by both registers, at their extremes and at the boundary
	task automatic test_gating();
		drain_results();
		write_reg(REG_UNLOADING, 64'd1);
		send_cmd(CMD_START, 1, 64'd5, 64'd1);
		send_cmd(CMD_STOP, 1, 64'd5, 64'd2);
		// discard and reset are never gated
		send_cmd(CMD_DISCARD, 5, '0, '0);
		send_cmd(CMD_RESET, 127, '0, '0);
		drain_results();
		write_reg(REG_UNLOADING, 64'd0);
		write_reg(REG_ACTIVE_EVENT, '1);
		send_cmd(CMD_START, 2, '1, 64'd3);
		drain_results();
		write_reg(REG_ACTIVE_EVENT, 64'd100);
		send_cmd(CMD_START, 2, 64'd100, 64'd4);
		send_cmd(CMD_START, 2, 64'd101, 64'd7);
		send_cmd(CMD_STOP, 2, 64'd101, 64'd9);
	endtask

	task automatic test_random_traffic();
		run_traffic(400, 1'b0, '0, 1'b0, 1'b1);
		run_traffic(300, 1'b0, 64'($urandom_range(1, 40)), 1'b0, 1'b1);
		run_traffic(60, 1'b1, '0, 1'b0, 1'b0);
		run_traffic(60, 1'b0, '1, 1'b0, 1'b0);
		run_traffic(120, 1'b0, rand64(), 1'b0, 1'b0);
		// back-to-back transfers, no gaps at all
		run_traffic(180, 1'b0, '0, 1'b1, 1'b0);
	endtask

	initial begin
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		start      <= 1'b0;
		cmd        <= CMD_READ;
		counter_id <= '0;
		event_id   <= '0;
		now_ticks  <= '0;
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			mark_time[i]  = '0;
			mark_event[i] = '0;
			occ_tab[i]    = '0;
			sum_tab[i]    = '0;
			peak_tab[i]   = '0;
		end
		cfg_unloading = 1'b0;
		cfg_active    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_gating();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
